// ===== rtl/core/nsc_pkg.sv =====
// Shared types and constants for the NMEA sentence checker.
// Used by nsc_line_tracker and nmea_sentence_checker; depends on nothing.
`default_nettype none

package nsc_pkg;

	// Characters with special meaning on the line
	localparam logic [7:0] CH_DOLLAR = 8'h24;
	localparam logic [7:0] CH_COMMA  = 8'h2C;
	localparam logic [7:0] CH_STAR   = 8'h2A;
	localparam logic [7:0] CH_CR     = 8'h0D;
	localparam logic [7:0] CH_LF     = 8'h0A;

	localparam logic [7:0] MAX_LENGTH_RESET = 8'd82;

	// Checksum digit parser codes
	localparam logic [1:0] DIG_WAIT = 2'd0;
	localparam logic [1:0] DIG_ONE  = 2'd1;
	localparam logic [1:0] DIG_TWO  = 2'd2;
	localparam logic [1:0] DIG_NONE = 2'd3;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       is_payload;
		logic [4:0] field_index;
		logic       line_end;
		logic       sentence_valid;
		logic       was_truncated;
		logic [4:0] field_count;
		logic [7:0] line_length;
	} result_t;

	typedef struct packed {
		logic       ok;
		logic [3:0] value;
	} hex_t;

	function automatic hex_t hex_decode(input logic [7:0] b);
		hex_t h;
		h.ok    = 1'b1;
		h.value = 4'd0;
		case (b) inside
			[8'h30:8'h39]: h.value = 4'(b - 8'h30);
			[8'h41:8'h46]: h.value = 4'(b - 8'h41 + 8'd10);
			[8'h61:8'h66]: h.value = 4'(b - 8'h61 + 8'd10);
			default:       h.ok    = 1'b0;
		endcase
		return h;
	endfunction

endpackage

`default_nettype wire

// ===== rtl/core/nmea_sentence_checker.sv =====
// Top level of the NMEA sentence checker: byte channel, config register, result register.
// Depends on nsc_pkg and nsc_line_tracker.
`default_nettype none

// Feed one received character per beat on rx_byte; each beat yields exactly one result
// beat in the next cycle, carrying the byte, its payload flag, the running field and
// comma counts, the line length and, on the beat that closes a line (LF or the
// max_length limit), the valid and truncated flags. One byte is taken every cycle
// while in_stall is low: the line state updates in the accepting cycle and a single
// result register holds the answer, so in_stall is raised only while that register
// is full and out_stall is high. max_length resets to 82; the user must write it through
// cfg_wr_en/cfg_wr_data while the channel is quiet; the block does not enforce it.
module nmea_sentence_checker #(
	parameter int FIELD_LIMIT = 31
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       cfg_wr_en,
	input  wire logic [7:0] cfg_wr_data,
	input  wire logic       in_valid,
	output logic            in_stall,
	input  wire logic [7:0] rx_byte,
	output logic            out_valid,
	input  wire logic       out_stall,
	output logic [7:0]      data_byte,
	output logic            is_payload,
	output logic [4:0]      field_index,
	output logic            line_end,
	output logic            sentence_valid,
	output logic            was_truncated,
	output logic [4:0]      field_count,
	output logic [7:0]      line_length
);
	import nsc_pkg::*;

	logic [7:0] max_length_q;
	logic       out_valid_q;
	result_t    result;
	result_t    result_q;
	logic       take;

	assign in_stall = out_valid_q && out_stall;
	assign take     = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			max_length_q <= MAX_LENGTH_RESET;
		else if (cfg_wr_en)
			max_length_q <= cfg_wr_data;
	end

	nsc_line_tracker #(
		.FIELD_LIMIT(FIELD_LIMIT)
	) u_tracker (
		.clk        (clk),
		.arst_n     (arst_n),
		.take       (take),
		.rx_byte    (rx_byte),
		.max_length (max_length_q),
		.result     (result)
	);

	// result register: load on accept, drop when taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (take)
			out_valid_q <= 1'b1;
		else if (!out_stall)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (take)
			result_q <= result;
	end

	assign out_valid      = out_valid_q;
	assign data_byte      = result_q.data_byte;
	assign is_payload     = result_q.is_payload;
	assign field_index    = result_q.field_index;
	assign line_end       = result_q.line_end;
	assign sentence_valid = result_q.sentence_valid;
	assign was_truncated  = result_q.was_truncated;
	assign field_count    = result_q.field_count;
	assign line_length    = result_q.line_length;

endmodule

`default_nettype wire

// ===== rtl/core/nsc_line_tracker.sv =====
// Per-line state of the sentence checker and the result for each byte.
// Depends on nsc_pkg.
`default_nettype none

module nsc_line_tracker #(
	parameter int FIELD_LIMIT = 31
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            take,
	input  wire logic [7:0]      rx_byte,
	input  wire logic [7:0]      max_length,
	output nsc_pkg::result_t     result
);
	import nsc_pkg::*;

	localparam int         CAP_INT   = (FIELD_LIMIT < 31) ? FIELD_LIMIT : 31;
	localparam logic [4:0] COUNT_CAP = 5'(CAP_INT);

	logic       in_sentence_q,  in_sentence_d;
	logic [7:0] payload_cnt_q,  payload_cnt_d;
	logic [7:0] running_xor_q,  running_xor_d;
	logic [7:0] body_xor_q,     body_xor_d;
	logic       body_marked_q,  body_marked_d;
	logic       since_dollar_q, since_dollar_d;
	logic [1:0] digit_cnt_q,    digit_cnt_d;
	logic [7:0] sent_sum_q,     sent_sum_d;
	logic [4:0] comma_cnt_q,    comma_cnt_d;
	logic [4:0] delim_cnt_q,    delim_cnt_d;
	logic       stored;
	logic       ends;
	logic       trunc;
	hex_t       hex;

	function automatic logic [4:0] bump(input logic [4:0] v);
		return (v < COUNT_CAP) ? 5'(v + 5'd1) : v;
	endfunction

	assign hex = hex_decode(rx_byte);

	always_comb begin
		in_sentence_d  = in_sentence_q;
		running_xor_d  = running_xor_q;
		body_xor_d     = body_xor_q;
		body_marked_d  = body_marked_q;
		since_dollar_d = since_dollar_q;
		digit_cnt_d    = digit_cnt_q;
		sent_sum_d     = sent_sum_q;
		comma_cnt_d    = comma_cnt_q;
		delim_cnt_d    = delim_cnt_q;
		stored         = 1'b0;

		if (rx_byte == CH_DOLLAR) begin
			// restart the checksum body; field counts carry on
			delim_cnt_d    = bump(delim_cnt_q);
			in_sentence_d  = 1'b1;
			running_xor_d  = 8'd0;
			body_xor_d     = 8'd0;
			body_marked_d  = 1'b0;
			since_dollar_d = 1'b0;
			digit_cnt_d    = DIG_WAIT;
			sent_sum_d     = 8'd0;
			stored         = 1'b1;
		end else if (rx_byte == CH_CR || rx_byte == CH_LF) begin
			if (in_sentence_q) begin
				delim_cnt_d   = bump(delim_cnt_q);
				in_sentence_d = 1'b0;
			end
		end else if (rx_byte == CH_STAR) begin
			delim_cnt_d = bump(delim_cnt_q);
			if (in_sentence_q) begin
				// snapshot the body sum; a later star takes a new one
				body_marked_d  = since_dollar_q;
				body_xor_d     = running_xor_q;
				digit_cnt_d    = DIG_WAIT;
				sent_sum_d     = 8'd0;
				running_xor_d  = running_xor_q ^ rx_byte;
				since_dollar_d = 1'b1;
				stored         = 1'b1;
			end
		end else begin
			if (rx_byte == CH_COMMA)
				delim_cnt_d = bump(delim_cnt_q);
			if (in_sentence_q) begin
				if (rx_byte == CH_COMMA && !body_marked_q)
					comma_cnt_d = bump(comma_cnt_q);
				if (body_marked_q && (digit_cnt_q == DIG_WAIT || digit_cnt_q == DIG_ONE)) begin
					if (hex.ok) begin
						sent_sum_d  = {sent_sum_q[3:0], hex.value};
						digit_cnt_d = 2'(digit_cnt_q + 2'd1);
					end else begin
						digit_cnt_d = (digit_cnt_q == DIG_WAIT) ? DIG_NONE : DIG_TWO;
					end
				end
				running_xor_d  = running_xor_q ^ rx_byte;
				since_dollar_d = 1'b1;
				stored         = 1'b1;
			end
		end

		payload_cnt_d = 8'(payload_cnt_q + {7'd0, stored});
		ends  = (rx_byte == CH_LF) || (payload_cnt_d >= max_length);
		trunc = ends && in_sentence_d;

		result.data_byte      = rx_byte;
		result.is_payload     = stored;
		result.field_index    = delim_cnt_d;
		result.line_end       = ends;
		result.was_truncated  = trunc;
		result.sentence_valid = ends && !trunc && body_marked_d &&
			(digit_cnt_d == DIG_ONE || digit_cnt_d == DIG_TWO) &&
			(sent_sum_d == body_xor_d);
		result.field_count    = comma_cnt_d;
		result.line_length    = payload_cnt_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_sentence_q  <= 1'b0;
			payload_cnt_q  <= 8'd0;
			running_xor_q  <= 8'd0;
			body_xor_q     <= 8'd0;
			body_marked_q  <= 1'b0;
			since_dollar_q <= 1'b0;
			digit_cnt_q    <= DIG_WAIT;
			sent_sum_q     <= 8'd0;
			comma_cnt_q    <= 5'd0;
			delim_cnt_q    <= 5'd0;
		end else if (take) begin
			if (ends) begin
				// line closed: start clean
				in_sentence_q  <= 1'b0;
				payload_cnt_q  <= 8'd0;
				running_xor_q  <= 8'd0;
				body_xor_q     <= 8'd0;
				body_marked_q  <= 1'b0;
				since_dollar_q <= 1'b0;
				digit_cnt_q    <= DIG_WAIT;
				sent_sum_q     <= 8'd0;
				comma_cnt_q    <= 5'd0;
				delim_cnt_q    <= 5'd0;
			end else begin
				in_sentence_q  <= in_sentence_d;
				payload_cnt_q  <= payload_cnt_d;
				running_xor_q  <= running_xor_d;
				body_xor_q     <= body_xor_d;
				body_marked_q  <= body_marked_d;
				since_dollar_q <= since_dollar_d;
				digit_cnt_q    <= digit_cnt_d;
				sent_sum_q     <= sent_sum_d;
				comma_cnt_q    <= comma_cnt_d;
				delim_cnt_q    <= delim_cnt_d;
			end
		end
	end

endmodule

`default_nettype wire

// ===== rtl/core/nsc_assert.sv =====
// Port-level checks for nmea_sentence_checker, bound to the top level.
// Depends on nothing but the top level's ports.
`default_nettype none

module nsc_assert (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       in_stall,
	input wire logic       out_valid,
	input wire logic       out_stall,
	input wire logic [7:0] data_byte,
	input wire logic       is_payload,
	input wire logic       line_end,
	input wire logic       sentence_valid,
	input wire logic       was_truncated,
	input wire logic [7:0] line_length
);

	// hold a stalled result beat
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(data_byte) && $stable(line_length))
		else $error("stalled result beat changed");

	// input stalls only behind a full, stalled result register
	a_in_stall: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid && out_stall)
		else $error("input stalled with room in result register");

	// line flags only on a closing beat
	a_flags_end: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !line_end |-> !sentence_valid && !was_truncated)
		else $error("line flags without line end");

	a_valid_trunc: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && sentence_valid |-> !was_truncated)
		else $error("sentence both valid and truncated");

	a_payload_len: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && is_payload |-> line_length != 8'd0)
		else $error("payload byte with zero line length");

endmodule

bind nmea_sentence_checker nsc_assert u_nsc_assert (.*);

`default_nettype wire

// ===== tb/tb_nmea_sentence_checker.sv =====
// Self-checking bench for nmea_sentence_checker: drives byte beats, tracks line state
// in a local parser model and compares every result beat field by field.
// Depends on nsc_pkg and the nmea_sentence_checker RTL.
`default_nettype none

module tb_nmea_sentence_checker;
	timeunit 1ns;
	timeprecision 1ps;

	import nsc_pkg::*;

	localparam int FIELD_LIMIT = 31;
	localparam int FIELD_CAP   = (FIELD_LIMIT < 31) ? FIELD_LIMIT : 31;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       cfg_wr_en = 1'b0;
	logic [7:0] cfg_wr_data = 8'h00;
	logic       in_valid = 1'b0;
	logic       in_stall;
	logic [7:0] rx_byte = 8'h00;
	logic       out_valid;
	logic       out_stall = 1'b0;
	logic [7:0] data_byte;
	logic       is_payload;
	logic [4:0] field_index;
	logic       line_end;
	logic       sentence_valid;
	logic       was_truncated;
	logic [4:0] field_count;
	logic [7:0] line_length;

	nmea_sentence_checker #(
		.FIELD_LIMIT(FIELD_LIMIT)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_wr_en(cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.rx_byte(rx_byte),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.data_byte(data_byte),
		.is_payload(is_payload),
		.field_index(field_index),
		.line_end(line_end),
		.sentence_valid(sentence_valid),
		.was_truncated(was_truncated),
		.field_count(field_count),
		.line_length(line_length)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// Line parser state, mirrored from the block
	logic       open_sentence;
	logic [7:0] stored_cnt;
	logic [7:0] xor_acc;
	logic [7:0] star_xor;
	logic       star_ok;
	logic       seen_text;
	logic [1:0] digit_state;
	logic [7:0] sum_sent;
	logic [4:0] comma_cnt;
	logic [4:0] delim_cnt;
	logic [7:0] max_len;

	logic [7:0] rx_q[$];
	result_t    status_q[$];
	int         mismatches = 0;

	function automatic logic [4:0] sat_inc(input logic [4:0] v);
		return (v < FIELD_CAP) ? v + 5'd1 : v;
	endfunction

	// {ok, value} for one ASCII hex digit
	function automatic logic [4:0] hex_nibble(input logic [7:0] b);
		if (b >= 8'h30 && b <= 8'h39) return {1'b1, 4'(b - 8'h30)};
		if (b >= 8'h41 && b <= 8'h46) return {1'b1, 4'(b - 8'h37)};
		if (b >= 8'h61 && b <= 8'h66) return {1'b1, 4'(b - 8'h57)};
		return 5'd0;
	endfunction

	function automatic void clear_line_state();
		open_sentence = 1'b0;
		stored_cnt    = 8'd0;
		xor_acc       = 8'd0;
		star_xor      = 8'd0;
		star_ok       = 1'b0;
		seen_text     = 1'b0;
		digit_state   = DIG_WAIT;
		sum_sent      = 8'd0;
		comma_cnt     = 5'd0;
		delim_cnt     = 5'd0;
	endfunction

	// Advance the line state by one byte and return the status it reports
	function automatic result_t next_status(input logic [7:0] b);
		result_t    r;
		logic       stored;
		logic       ends;
		logic       trunc;
		logic [4:0] nib;
		stored = 1'b0;
		if (b == CH_DOLLAR) begin
			delim_cnt     = sat_inc(delim_cnt);
			open_sentence = 1'b1;
			xor_acc       = 8'd0;
			star_xor      = 8'd0;
			star_ok       = 1'b0;
			seen_text     = 1'b0;
			digit_state   = DIG_WAIT;
			sum_sent      = 8'd0;
			stored        = 1'b1;
		end else if (b == CH_CR || b == CH_LF) begin
			if (open_sentence) begin
				delim_cnt     = sat_inc(delim_cnt);
				open_sentence = 1'b0;
			end
		end else if (b == CH_STAR) begin
			delim_cnt = sat_inc(delim_cnt);
			if (open_sentence) begin
				star_ok     = seen_text;
				star_xor    = xor_acc;
				digit_state = DIG_WAIT;
				sum_sent    = 8'd0;
				xor_acc     = xor_acc ^ b;
				seen_text   = 1'b1;
				stored      = 1'b1;
			end
		end else begin
			if (b == CH_COMMA) delim_cnt = sat_inc(delim_cnt);
			if (open_sentence) begin
				if (b == CH_COMMA && !star_ok) comma_cnt = sat_inc(comma_cnt);
				if (star_ok && (digit_state == DIG_WAIT || digit_state == DIG_ONE)) begin
					nib = hex_nibble(b);
					if (nib[4]) begin
						sum_sent    = {sum_sent[3:0], nib[3:0]};
						digit_state = (digit_state == DIG_WAIT) ? DIG_ONE : DIG_TWO;
					end else begin
						digit_state = (digit_state == DIG_WAIT) ? DIG_NONE : DIG_TWO;
					end
				end
				xor_acc   = xor_acc ^ b;
				seen_text = 1'b1;
				stored    = 1'b1;
			end
		end
		if (stored) stored_cnt = stored_cnt + 8'd1;
		ends  = (b == CH_LF) || (stored_cnt >= max_len);
		trunc = ends && open_sentence;
		r.data_byte      = b;
		r.is_payload     = stored;
		r.field_index    = delim_cnt;
		r.line_end       = ends;
		r.sentence_valid = ends && !trunc && star_ok &&
			(digit_state == DIG_ONE || digit_state == DIG_TWO) && sum_sent == star_xor;
		r.was_truncated  = trunc;
		r.field_count    = comma_cnt;
		r.line_length    = stored_cnt;
		if (ends) clear_line_state();
		return r;
	endfunction

	task automatic compare_field(input string name, input logic [7:0] want,
		input logic [7:0] got);
		if (want !== got) begin
			mismatches++;
			$display("%0t: %s expected %0h got %0h", $time, name, want, got);
		end
	endtask

	// Sender: bursts of random length, random gaps between them
	int burst_left = 0;
	int gap_left = 0;

	always @(posedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else if (!in_valid || !in_stall) begin
			if (gap_left != 0) begin
				gap_left <= gap_left - 1;
				in_valid <= 1'b0;
			end else if (rx_q.size() != 0) begin
				in_valid <= 1'b1;
				rx_byte  <= rx_q.pop_front();
				if (burst_left <= 1) begin
					burst_left <= $urandom_range(1, 24);
					gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
				end else begin
					burst_left <= burst_left - 1;
				end
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// Receiver: stall mode switches at random intervals (none, random, mostly stalled)
	logic [1:0] stall_mode = 2'd0;
	int         mode_left = 0;

	always @(posedge clk) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin
			if (mode_left == 0) begin
				stall_mode <= 2'($urandom_range(0, 2));
				mode_left  <= $urandom_range(20, 80);
			end else begin
				mode_left <= mode_left - 1;
			end
			case (stall_mode)
				2'd0:    out_stall <= 1'b0;
				2'd1:    out_stall <= 1'($urandom_range(0, 1));
				default: out_stall <= ($urandom_range(0, 7) != 0);
			endcase
		end
	end

	// Predict on each accepted byte, check each accepted result
	always @(posedge clk) begin
		result_t want;
		if (arst_n) begin
			if (in_valid && !in_stall) status_q.push_back(next_status(rx_byte));
			if (out_valid && !out_stall) begin
				if (status_q.size() == 0) begin
					mismatches++;
					$display("%0t: result beat %0h with none expected", $time, data_byte);
				end else begin
					want = status_q.pop_front();
					compare_field("data_byte", want.data_byte, data_byte);
					compare_field("is_payload", 8'(want.is_payload), 8'(is_payload));
					compare_field("field_index", 8'(want.field_index), 8'(field_index));
					compare_field("line_end", 8'(want.line_end), 8'(line_end));
					compare_field("sentence_valid", 8'(want.sentence_valid),
						8'(sentence_valid));
					compare_field("was_truncated", 8'(want.was_truncated), 8'(was_truncated));
					compare_field("field_count", 8'(want.field_count), 8'(field_count));
					compare_field("line_length", want.line_length, line_length);
				end
			end
		end
	end

	function automatic logic [7:0] hex_char(input logic [3:0] n, input logic upper);
		if (n < 4'd10) return 8'h30 + 8'(n);
		return (upper ? 8'h37 : 8'h57) + 8'(n);
	endfunction

	function automatic logic [7:0] body_char();
		int pick;
		pick = $urandom_range(0, 19);
		if (pick < 3) return CH_COMMA;
		if (pick == 3) return 8'($urandom_range(0, 255));
		return 8'($urandom_range(8'h20, 8'h7E));
	endfunction

	task automatic push_text(input string s);
		for (int i = 0; i < s.len(); i++) rx_q.push_back(s[i]);
	endtask

	task automatic push_sum(input logic [7:0] s);
		logic upper;
		upper = 1'($urandom_range(0, 1));
		rx_q.push_back(hex_char(s[7:4], upper));
		rx_q.push_back(hex_char(s[3:0], upper));
	endtask

	// Mostly well-formed sentences with random text; some noise and broken lines
	task automatic add_sentence(input int body_max);
		logic [7:0] sum;
		logic [7:0] c;
		int         n;
		int         form;
		form = $urandom_range(0, 99);
		if (form < 8) begin
			n = $urandom_range(1, 6);
			repeat (n) rx_q.push_back(8'($urandom_range(0, 255)));
			return;
		end
		rx_q.push_back(CH_DOLLAR);
		sum = 8'h00;
		n = $urandom_range(0, body_max);
		repeat (n) begin
			c = body_char();
			rx_q.push_back(c);
			sum ^= c;
		end
		if (form < 18) begin
			case ($urandom_range(0, 3))
				0: rx_q.push_back(CH_LF);
				1: rx_q.push_back(CH_DOLLAR);
				2: begin
					rx_q.push_back(CH_STAR);
					rx_q.push_back(8'h5A);
					rx_q.push_back(CH_LF);
				end
				default: ;
			endcase
			return;
		end
		rx_q.push_back(CH_STAR);
		case ($urandom_range(0, 5))
			0, 1: push_sum(sum);
			2: rx_q.push_back(hex_char(sum[3:0], 1'($urandom_range(0, 1))));
			3: push_sum(sum ^ 8'($urandom_range(1, 255)));
			4: begin
				push_sum(sum);
				rx_q.push_back(hex_char(4'($urandom_range(0, 15)), 1'b1));
			end
			default: rx_q.push_back(8'h67);
		endcase
		if ($urandom_range(0, 3) != 0) begin
			rx_q.push_back(CH_CR);
			if ($urandom_range(0, 4) == 0) rx_q.push_back(body_char());
		end
		rx_q.push_back(CH_LF);
	endtask

	task automatic fill_random(input int count, input int body_max);
		@(negedge clk);
		while (rx_q.size() < count) add_sentence(body_max);
	endtask

	task automatic wait_until_quiet();
		do @(negedge clk);
		while (rx_q.size() != 0 || in_valid || status_q.size() != 0);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_max_length(input logic [7:0] v);
		@(posedge clk);
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= v;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		max_len = v;
	endtask

	initial begin
		#20000000;
		$display("*** FAILED ***");
		$finish;
	end

	initial begin
		max_len = MAX_LENGTH_RESET;
		clear_line_state();
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// Directed: stray bytes at both extremes, comma field, empty body with
		// non-hex digit, repeated dollar ended by CR, repeated star with lowercase sum
		@(negedge clk);
		rx_q.push_back(8'h00);
		rx_q.push_back(8'hFF);
		push_text("$A,*6D");
		rx_q.push_back(CH_LF);
		push_text("$*X");
		rx_q.push_back(CH_LF);
		push_text("$B$C*43");
		rx_q.push_back(CH_CR);
		rx_q.push_back(CH_LF);
		push_text("$D*E*2b");
		rx_q.push_back(CH_LF);
		fill_random(100, 12);
		wait_until_quiet();

		// Longest line: cut off at 255, field counts saturate, trailing commas still delimit
		write_max_length(8'd255);
		@(negedge clk);
		rx_q.push_back(CH_DOLLAR);
		repeat (260) rx_q.push_back(CH_COMMA);
		rx_q.push_back(CH_LF);
		fill_random(300, 40);
		wait_until_quiet();

		write_max_length(8'd8);
		fill_random(60, 12);
		wait_until_quiet();

		// Below the stated range: every byte, then every stored byte, closes the line
		write_max_length(8'd0);
		fill_random(20, 6);
		wait_until_quiet();
		write_max_length(8'd1);
		fill_random(20, 6);
		wait_until_quiet();

		repeat (2) begin
			write_max_length(8'($urandom_range(8, 255)));
			fill_random(50, 16);
			wait_until_quiet();
		end

		repeat (10) @(posedge clk);
		if (mismatches == 0 && status_q.size() == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule

`default_nettype wire
